@@ rtl/tsi_pkg.sv @@
// Package for the timestamped sample interpolator: shared types and constants.
// No dependencies.
package tsi_pkg;

  localparam int TimeW = 32;
  localparam int PoseW = 32;
  localparam int FlagW = 8;
  localparam int DelayW = 20;
  localparam int WeightW = 17;

  // configuration register indexes
  localparam logic [0:0] REG_DELAY = 1'b0;
  localparam logic [0:0] REG_ALIVE = 1'b1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // one stored sample: time, five pose words, flag byte
  typedef struct packed {
    logic [TimeW-1:0] ts;
    logic [PoseW-1:0] px;
    logic [PoseW-1:0] py;
    logic [PoseW-1:0] pz;
    logic [PoseW-1:0] pyaw;
    logic [PoseW-1:0] ppitch;
    logic [FlagW-1:0] flags;
  } sample_t;

  localparam int SampleW = $bits(sample_t);

endpackage

@@ rtl/tsi_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module tsi_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tsi_div.sv @@
// Radix-2 restoring divider: quotient of a 49-bit numerator by a 33-bit
// divisor, one bit per cycle. Uses tsi_pkg.
module tsi_div
  import tsi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [48:0]        num,
  input  logic [TimeW:0]     den,
  output logic               done,
  output logic [48:0]        quo
);

  logic [5:0]       cnt;
  logic             run;
  logic [TimeW+1:0] rem;
  logic [48:0]      nsh;
  logic [TimeW:0]   dv;
  logic [TimeW+1:0] trial;
  logic [TimeW+1:0] diff;

  assign trial = {rem[TimeW:0], nsh[48]};
  assign diff  = trial - {1'b0, dv};

  // shift one numerator bit per cycle into the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd49;
        rem <= '0;
        nsh <= num;
        dv <= den;
        quo <= '0;
      end else if (run) begin
        nsh <= {nsh[47:0], 1'b0};
        if (!diff[TimeW+1]) begin
          rem <= diff;
          quo <= {quo[47:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[47:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/tsi_blend.sv @@
// Blend of one pose word: older + floor((newer - older) * t / 65536).
// Two registered stages. Uses tsi_pkg.
module tsi_blend
  import tsi_pkg::*;
(
  input  logic                 clk,
  input  logic [PoseW-1:0]     older,
  input  logic [PoseW-1:0]     newer,
  input  logic [WeightW-1:0]   weight,
  output logic [PoseW-1:0]     res
);

  logic signed [PoseW:0]        d;
  logic signed [PoseW+WeightW+1:0] prod;
  logic [PoseW-1:0]             old_q;

  // stage 1: difference of newer and older, with the older value registered alongside
  always_ff @(posedge clk) begin
    d <= $signed({newer[PoseW-1], newer}) - $signed({older[PoseW-1], older});
    old_q <= older;
  end

  // stage 2: difference times weight; the arithmetic shift floors, then the older value is added back
  always_ff @(posedge clk) begin
    prod <= d * $signed({1'b0, weight});
  end

  assign res = old_q + prod[PoseW+15:16];

endmodule

@@ rtl/timestamped_sample_interpolator_top.sv @@
// Timestamped sample interpolator: top level with sequencer and sample ring.
// Uses tsi_pkg, tsi_ram, tsi_div, tsi_blend.
// Push: writes at head, then prunes stale samples from the old end (PRUNE, PCHK per sample). Query:
// walks back from the newest sample (WALK, WCHK per sample), then divides if needed (S_DIV),
// blends and outputs; the result strobes once and cannot be stalled.
// Reset clears the ring pointers; ring contents are not cleared.
module timestamped_sample_interpolator_top
  import tsi_pkg::*;
#(
  parameter int RING_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              command,
  input  logic [31:0]       timestamp,
  input  logic [31:0]       pos_x,
  input  logic [31:0]       pos_y,
  input  logic [31:0]       pos_z,
  input  logic [31:0]       yaw,
  input  logic [31:0]       pitch,
  input  logic [7:0]        state_flags,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              done,
  output logic              found,
  output logic              alive,
  output logic [31:0]       out_x,
  output logic [31:0]       out_y,
  output logic [31:0]       out_z,
  output logic [31:0]       out_yaw,
  output logic [31:0]       out_pitch,
  output logic [7:0]        out_flags
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam logic [CW-1:0] FullCnt = CW'(RING_DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(RING_DEPTH - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PRUNE = 9'b000000010,
    S_PCHK  = 9'b000000100,
    S_WALK  = 9'b000001000,
    S_WCHK  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_BLEND = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_WAIT  = 9'b100000000
  } state_t;

  state_t state;
  logic [DelayW-1:0] delay;
  logic [FlagW-1:0]  amask;
  logic [AW-1:0]     head;
  logic [CW-1:0]     count;
  logic [CW-1:0]     k;
  logic              cmd;
  logic [TimeW-1:0]  now;
  logic [TimeW-1:0]  render;
  logic              has_new;
  logic              has_old;
  sample_t           newer;
  sample_t           older;
  logic [WeightW-1:0] weight;
  logic [1:0]        bcnt;

  logic              we;
  logic [AW-1:0]     waddr;
  sample_t           wdata;
  logic [AW-1:0]     raddr;
  sample_t           rdata;

  logic              div_start;
  logic              div_done;
  logic [48:0]       div_num;
  logic [TimeW:0]    div_den;
  logic [48:0]       div_quo;

  logic [PoseW-1:0]  bx, by, bz, byaw, bpitch;

  tsi_ram #(.Width(SampleW), .Depth(RING_DEPTH)) u_ring (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  tsi_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  tsi_blend u_bx (.clk(clk), .older(older.px), .newer(newer.px), .weight(weight), .res(bx));
  tsi_blend u_by (.clk(clk), .older(older.py), .newer(newer.py), .weight(weight), .res(by));
  tsi_blend u_bz (.clk(clk), .older(older.pz), .newer(newer.pz), .weight(weight), .res(bz));
  tsi_blend u_byaw (.clk(clk), .older(older.pyaw), .newer(newer.pyaw), .weight(weight),
                    .res(byaw));
  tsi_blend u_bpitch (.clk(clk), .older(older.ppitch), .newer(newer.ppitch),
                      .weight(weight), .res(bpitch));

  // slot 'back' positions behind the newest sample
  function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] h, input logic [CW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, LastIdx} - {1'b0, b[AW-1:0]};
    if (s >= (AW+1)'(RING_DEPTH)) s = s - (AW+1)'(RING_DEPTH);
    if (s >= (AW+1)'(RING_DEPTH)) s = s - (AW+1)'(RING_DEPTH);
    return s[AW-1:0];
  endfunction

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // write port: push writes at head when the item is taken
  assign we = start && !busy && (command == CMD_PUSH);
  assign waddr = head;
  assign wdata = '{ts: timestamp, px: pos_x, py: pos_y, pz: pos_z, pyaw: yaw,
                   ppitch: pitch, flags: state_flags};

  // read address: oldest kept sample while pruning, k back while walking
  always_comb begin
    if (state == S_PRUNE || state == S_PCHK) begin
      raddr = slot_back(head, count - CW'(1));
    end else begin
      raddr = slot_back(head, k);
    end
  end

  // pruning age test, signed 35-bit
  logic signed [TimeW+2:0] age;
  logic [TimeW+2:0]        keep;
  assign age  = $signed({3'b0, now}) - $signed({3'b0, rdata.ts});
  assign keep = {13'b0, delay, 2'b00};

  logic span_big;
  logic [TimeW:0] span_w;
  assign span_w = {1'b0, newer.ts} - {1'b0, older.ts};
  assign span_big = span_w > (TimeW+1)'(1);

  // divider start pulse: first cycle of the divide state with a real span
  assign div_num = {17'b0, render - older.ts} << 16;
  assign div_den = {1'b0, newer.ts} - {1'b0, older.ts};
  assign div_start = (state == S_DIV) && has_new && has_old && (bcnt == 2'd0) && span_big;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      delay <= DelayW'(100000);
      amask <= FlagW'(1);
      head <= '0;
      count <= '0;
      done <= 1'b0;
      bcnt <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DELAY: delay <= cfg_data[DelayW-1:0];
          REG_ALIVE: amask <= cfg_data[FlagW-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            now <= timestamp;
            render <= (timestamp > {12'b0, delay}) ? timestamp - {12'b0, delay} : '0;
            k <= '0;
            cmd <= command;
            has_new <= 1'b0;
            has_old <= 1'b0;
            if (command == CMD_PUSH) begin
              head <= (head == LastIdx) ? '0 : head + AW'(1);
              if (count != FullCnt) count <= count + CW'(1);
              state <= S_WAIT;
            end else if (count == '0) begin
              found <= 1'b0;
              alive <= 1'b0;
              out_x <= '0; out_y <= '0; out_z <= '0;
              out_yaw <= '0; out_pitch <= '0; out_flags <= '0;
              done <= 1'b1;
              state <= S_WAIT;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WAIT: begin
          // after a push, prune; after a query, back to idle
          if (cmd == CMD_PUSH) state <= S_PRUNE;
          else state <= S_IDLE;
        end
        S_PRUNE: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          if (count > CW'(1) && age > $signed(keep)) begin
            count <= count - CW'(1);
            state <= S_PRUNE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_WALK: begin
          state <= S_WCHK;
        end
        S_WCHK: begin
          if (rdata.ts >= render) begin
            has_new <= 1'b1;
            newer <= rdata;
            if (k + CW'(1) == count) begin
              older <= rdata;
              bcnt <= 2'd3;
              state <= S_DIV;
            end else begin
              k <= k + CW'(1);
              state <= S_WALK;
            end
          end else begin
            has_old <= 1'b1;
            older <= rdata;
            if (!has_new) newer <= rdata;
            bcnt <= 2'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (bcnt == 2'd3 || !has_new) begin
            // single side: take the sample as is
            weight <= '0;
            older <= (has_new) ? newer : older;
            bcnt <= 2'd2;
            state <= S_BLEND;
          end else if (bcnt == 2'd0) begin
            if (!span_big) begin
              weight <= '0;
              bcnt <= 2'd2;
              state <= S_BLEND;
            end else begin
              bcnt <= 2'd1;
            end
          end else if (div_done) begin
            weight <= (div_quo > 49'd65536) ? WeightW'(65536) : div_quo[WeightW-1:0];
            bcnt <= 2'd2;
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          bcnt <= bcnt - 2'd1;
          if (bcnt == 2'd0) state <= S_OUT;
        end
        S_OUT: begin
          found <= 1'b1;
          out_x <= bx; out_y <= by; out_z <= bz;
          out_yaw <= byaw; out_pitch <= bpitch;
          out_flags <= (has_new && has_old) ? newer.flags : older.flags;
          alive <= (((has_new && has_old) ? newer.flags : older.flags) & amask) != '0;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= FullCnt)
    else $error("sample count above ring depth");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(busy) || state == S_IDLE || state == S_WAIT)
    else $error("result strobe while still working");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> (state == S_WCHK))
    else $error("walk read not followed by check");
`endif

endmodule

@@ verif/tsi_checker.sv @@
// Checker for the timestamped sample interpolator: watches the command and
// result channels, predicts each query answer and compares. Uses tsi_pkg.
`timescale 1ns / 100ps
module tsi_checker
  import tsi_pkg::*;
#(
  parameter int RING_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        command,
  input  logic [31:0] timestamp,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] yaw,
  input  logic [31:0] pitch,
  input  logic [7:0]  state_flags,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        done,
  input  logic        found,
  input  logic        alive,
  input  logic [31:0] out_x,
  input  logic [31:0] out_y,
  input  logic [31:0] out_z,
  input  logic [31:0] out_yaw,
  input  logic [31:0] out_pitch,
  input  logic [7:0]  out_flags,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic        found;
    logic        alive;
    logic [31:0] pose [5];
    logic [7:0]  flags;
  } pose_answer_t;

  // shadow of the ring
  logic [31:0] hist_time  [RING_DEPTH];
  logic [31:0] hist_pose  [RING_DEPTH][5];
  logic [7:0]  hist_flags [RING_DEPTH];
  int          hist_head;
  int          hist_count;
  logic [19:0] delay_us;
  logic [7:0]  live_mask;
  pose_answer_t answer_q[$];

  function automatic int slot_back(int back);
    return (hist_head + RING_DEPTH - 1 - (back % RING_DEPTH)) % RING_DEPTH;
  endfunction

  // older + floor((newer - older) * w / 65536)
  function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b, longint w);
    longint d;
    longint p;
    longint q;
    d = longint'($signed(b)) - longint'($signed(a));
    p = d * w;
    q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
    return 32'(longint'($signed(a)) + q);
  endfunction

  function automatic void store_sample(logic [31:0] now, logic [31:0] pv [5],
                                       logic [7:0] fl);
    longint keep;
    int o;
    keep = longint'(delay_us) * 4;
    hist_time[hist_head] = now;
    hist_pose[hist_head] = pv;
    hist_flags[hist_head] = fl;
    hist_head = (hist_head + 1) % RING_DEPTH;
    if (hist_count < RING_DEPTH) hist_count++;
    // drop stale samples from the old end, keeping one
    while (hist_count > 1) begin
      o = slot_back(hist_count - 1);
      if (longint'(now) - longint'(hist_time[o]) <= keep) break;
      hist_count--;
    end
  endfunction

  function automatic pose_answer_t query_pose(logic [31:0] now);
    pose_answer_t r;
    logic [31:0] render;
    bit has_new;
    bit has_old;
    int ni;
    int oi;
    int s;
    longint span;
    longint num;
    longint w;
    has_new = 0;
    has_old = 0;
    ni = 0;
    oi = 0;
    r.found = 0;
    r.alive = 0;
    r.flags = '0;
    for (int i = 0; i < 5; i++) r.pose[i] = '0;
    if (hist_count == 0) return r;
    render = (now > 32'(delay_us)) ? now - 32'(delay_us) : '0;
    for (int k = 0; k < hist_count; k++) begin
      s = slot_back(k);
      if (hist_time[s] >= render) begin
        has_new = 1;
        ni = s;
      end else begin
        has_old = 1;
        oi = s;
        break;
      end
    end
    if (has_new && has_old) begin
      span = longint'(hist_time[ni]) - longint'(hist_time[oi]);
      w = 0;
      if (span > 1) begin
        num = longint'(render) - longint'(hist_time[oi]);
        w = (num < 0) ? 0 : (num * 65536) / span;
        if (w > 65536) w = 65536;
      end
      for (int i = 0; i < 5; i++) r.pose[i] = lerp(hist_pose[oi][i], hist_pose[ni][i], w);
      r.flags = hist_flags[ni];
    end else begin
      s = has_new ? ni : oi;
      r.pose = hist_pose[s];
      r.flags = hist_flags[s];
    end
    r.found = 1;
    r.alive = (r.flags & live_mask) != 0;
    return r;
  endfunction

  function automatic void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  assign pending = answer_q.size();

  always @(posedge clk) begin
    logic [31:0] pv [5];
    pose_answer_t e;
    if (rst) begin
      hist_head = 0;
      hist_count = 0;
      delay_us = 20'd100000;
      live_mask = 8'd1;
      answer_q.delete();
      fail_count = 0;
    end else begin
      // result side first: a result never stems from an item of this edge
      if (done) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result item");
          fail_count++;
        end else begin
          e = answer_q.pop_front();
          cmp("found", 32'(e.found), 32'(found));
          cmp("alive", 32'(e.alive), 32'(alive));
          cmp("out_x", e.pose[0], out_x);
          cmp("out_y", e.pose[1], out_y);
          cmp("out_z", e.pose[2], out_z);
          cmp("out_yaw", e.pose[3], out_yaw);
          cmp("out_pitch", e.pose[4], out_pitch);
          cmp("out_flags", 32'(e.flags), 32'(out_flags));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DELAY) delay_us = cfg_data[19:0];
        else live_mask = cfg_data[7:0];
      end
      if (start && !busy) begin
        if (command == CMD_PUSH) begin
          pv = '{pos_x, pos_y, pos_z, yaw, pitch};
          store_sample(timestamp, pv, state_flags);
        end else begin
          answer_q.push_back(query_pose(timestamp));
        end
      end
    end
  end

endmodule

@@ verif/tb_timestamped_sample_interpolator_top.sv @@
// Testbench top for the timestamped sample interpolator: drives pushes,
// queries and register writes; tsi_checker predicts and compares results.
`timescale 1ns / 100ps
module tb_timestamped_sample_interpolator_top;
  import tsi_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        command;
  logic [31:0] timestamp;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] yaw;
  logic [31:0] pitch;
  logic [7:0]  state_flags;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        done;
  logic        found;
  logic        alive;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [31:0] out_yaw;
  logic [31:0] out_pitch;
  logic [7:0]  out_flags;
  int          fail_count;
  int          pending;

  logic [31:0] clock_us;
  bit          no_gaps;

  timestamped_sample_interpolator_top uut (.*);
  tsi_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #20ms;
    $display("[timestamped_sample_interpolator_top] ERROR");
    $finish;
  end

  // one command item; random gap before it unless gaps are off
  task automatic send_item(logic cmd, logic [31:0] ts, logic [31:0] px,
                           logic [31:0] py, logic [31:0] pz, logic [31:0] yw,
                           logic [31:0] pt, logic [7:0] fl);
    while (!no_gaps && $urandom_range(99) < 11) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    command <= cmd;
    timestamp <= ts;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    yaw <= yw;
    pitch <= pt;
    state_flags <= fl;
    do @(posedge clk); while (busy);
  endtask

  task automatic push_rand(logic [31:0] ts);
    send_item(CMD_PUSH, ts, $urandom, $urandom, $urandom, $urandom, $urandom,
              8'($urandom));
  endtask

  task automatic query_at(logic [31:0] ts);
    send_item(CMD_QUERY, ts, $urandom, $urandom, $urandom, $urandom, $urandom,
              8'($urandom));
  endtask

  // register write only with the block idle and nothing outstanding
  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // a random stream: mostly rising push times (some step back), queries mostly near the recent span
  task automatic run_phase(int n, int step_max);
    logic [31:0] d;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) no_gaps = !no_gaps;
      if ($urandom_range(99) < 55) begin
        if ($urandom_range(99) < 5) clock_us = clock_us - $urandom_range(step_max);
        else clock_us = clock_us + $urandom_range(step_max);
        push_rand(clock_us);
      end else begin
        d = $urandom_range(3 * step_max);
        case ($urandom_range(9))
          0: query_at($urandom);
          1: query_at(clock_us - d);
          default: query_at(clock_us + 32'(chk.delay_us) - d);
        endcase
      end
    end
  endtask

  initial begin
    rst = 1;
    start = 0;
    command = CMD_PUSH;
    timestamp = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    yaw = '0;
    pitch = '0;
    state_flags = '0;
    cfg_valid = 0;
    cfg_index = REG_DELAY;
    cfg_data = '0;
    no_gaps = 0;
    clock_us = 32'd1000;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty ring, single sample, extremes, tight spans
    query_at(32'd500);
    send_item(CMD_PUSH, 32'd0, 32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff,
              32'h00010000, 8'hff);
    query_at(32'd0);
    query_at(32'hffffffff);
    send_item(CMD_PUSH, 32'd1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h0,
              32'hffff0000, 8'h00);
    query_at(32'd100001);
    send_item(CMD_PUSH, 32'd2, 32'h12345678, 32'h0, 32'h1, 32'h80000000,
              32'h7fffffff, 8'h01);
    query_at(32'd100001);
    send_item(CMD_PUSH, 32'd60000, 32'h7fffffff, 32'h80000000, 32'h55555555,
              32'haaaaaaaa, 32'h0, 8'hfe);
    query_at(32'd130000);
    query_at(32'd160000);
    query_at(32'd200000);
    send_item(CMD_PUSH, 32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'h80);
    query_at(32'hffffffff);
    query_at(32'd130000);
    push_rand(32'h10000000);
    query_at(32'h10000000);

    write_reg(REG_DELAY, 32'd0);
    write_reg(REG_ALIVE, 32'hff);
    clock_us = 32'd5000;
    run_phase(250, 40);
    write_reg(REG_DELAY, 32'hfffff);
    write_reg(REG_ALIVE, 32'h00);
    clock_us = 32'h00200000;
    run_phase(250, 400000);
    write_reg(REG_DELAY, 32'd1);
    write_reg(REG_ALIVE, 32'h80);
    run_phase(250, 6);
    write_reg(REG_DELAY, 32'd100);
    write_reg(REG_ALIVE, 32'h5a);
    run_phase(400, 150);
    write_reg(REG_DELAY, 32'd3000);
    write_reg(REG_ALIVE, 32'h01);
    clock_us = 32'hfff00000;
    run_phase(350, 2000);

    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("[timestamped_sample_interpolator_top] OK");
    else $display("[timestamped_sample_interpolator_top] ERROR");
    $finish;
  end

endmodule
